// File: rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package bsc_pkg;

	// Configuration port geometry
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Register indexes (word address paddr[4:2])
	localparam logic [2:0] REG_PRESS_SENS = 3'd0;
	localparam logic [2:0] REG_PRESS_OFF  = 3'd1;
	localparam logic [2:0] REG_SENS_TCO   = 3'd2;
	localparam logic [2:0] REG_OFF_TCO    = 3'd3;
	localparam logic [2:0] REG_TREF       = 3'd4;
	localparam logic [2:0] REG_TEMP_COEF  = 3'd5;

	// Arithmetic widths
	localparam int unsigned DT_W   = 25;  // D2 - C5*256
	localparam int unsigned PROD_W = 42;  // dT times a 16-bit coefficient
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned OFF_W  = 35;
	localparam int unsigned SENS_W = 34;
	localparam int unsigned PL_W   = 41;  // D1 times low 17 bits of SENS
	localparam int unsigned PH_W   = 42;  // D1 times high 17 bits of SENS
	localparam int unsigned FULL_W = 59;  // D1 * SENS
	localparam int unsigned Q_W    = 38;  // (D1 * SENS) >> 21
	localparam int unsigned DIFF_W = 39;
	localparam int unsigned P_W    = 24;

	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
	localparam logic [16:0] P_MAX = 17'd131071;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sens_temp_coef;
		logic [15:0] offset_temp_coef;
		logic [15:0] reference_temperature;
		logic [15:0] temp_coef;
	} cfg_t;

	typedef struct packed {
		logic [23:0] pressure_raw;
		logic [23:0] temperature_raw;
	} sample_t;

	typedef struct packed {
		logic signed [18:0] temperature_centi;
		logic [16:0]        pressure_centi;
		logic               pressure_saturated;
	} result_t;

	// Hand-off between the coefficient and pressure halves of the pipeline
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic [23:0]              d1;
	} comp_t;

endpackage

// File: rtl/baro_sensor_compensation.sv
// Throughput: one sample per cycle unless result_ready stalls the output;
// a six-stage pipeline, two partial products over the 17-bit halves of SENS
// carry the 24x34-bit D1*SENS multiply.
// Reset clears the calibration registers and all pipeline valid bits.
// Depends on bsc_pkg, bsc_cfg_regs, bsc_coef and bsc_press.
`timescale 1ns / 1ps

module baro_sensor_compensation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bsc_pkg::ADDR_W-1:0] paddr,
	input  logic [bsc_pkg::DATA_W-1:0] pwdata,
	output logic [bsc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  bsc_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output bsc_pkg::result_t           result
);
	import bsc_pkg::*;

	cfg_t  cfg;
	comp_t comp;
	logic  comp_valid;
	logic  comp_ready;

	bsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sample_valid),
		.in_ready  (sample_ready),
		.in_data   (sample),
		.out_valid (comp_valid),
		.out_ready (comp_ready),
		.out_data  (comp)
	);

	bsc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (comp_valid),
		.in_ready  (comp_ready),
		.in_data   (comp),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

endmodule

// File: rtl/bsc_cfg_regs.sv
// APB-style calibration register file (six 16-bit coefficients).
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bsc_pkg::ADDR_W-1:0] paddr,
	input  logic [bsc_pkg::DATA_W-1:0] pwdata,
	output logic [bsc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output bsc_pkg::cfg_t              cfg
);
	import bsc_pkg::*;

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  idx;
	logic [15:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRESS_SENS: cfg_q.pressure_sensitivity  <= pwdata[15:0];
				REG_PRESS_OFF:  cfg_q.pressure_offset       <= pwdata[15:0];
				REG_SENS_TCO:   cfg_q.sens_temp_coef        <= pwdata[15:0];
				REG_OFF_TCO:    cfg_q.offset_temp_coef      <= pwdata[15:0];
				REG_TREF:       cfg_q.reference_temperature <= pwdata[15:0];
				REG_TEMP_COEF:  cfg_q.temp_coef             <= pwdata[15:0];
				default: ;  // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRESS_SENS: rd_val = cfg_q.pressure_sensitivity;
			REG_PRESS_OFF:  rd_val = cfg_q.pressure_offset;
			REG_SENS_TCO:   rd_val = cfg_q.sens_temp_coef;
			REG_OFF_TCO:    rd_val = cfg_q.offset_temp_coef;
			REG_TREF:       rd_val = cfg_q.reference_temperature;
			REG_TEMP_COEF:  rd_val = cfg_q.temp_coef;
			default:        rd_val = 16'h0;
		endcase
	end

	assign prdata = {16'h0, rd_val};

endmodule

// File: rtl/bsc_coef.sv
// Stages 1 to 3: dT, the three dT products, then TEMP, OFF and SENS.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_coef (
	input  logic             clk,
	input  logic             arst_n,
	input  bsc_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  bsc_pkg::sample_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bsc_pkg::comp_t   out_data
);
	import bsc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [DT_W-1:0]   dt_s1;
	logic [23:0]              d1_s1, d1_s2;
	logic signed [PROD_W-1:0] p6_s2, p4_s2, p3_s2;
	comp_t                    comp_s3;

	logic signed [DT_W-1:0]   dt;
	logic signed [PROD_W-1:0] p6, p4, p3;
	comp_t                    comp;

	// A stage takes new data when it is empty or its content moves on
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: dT = D2 - C5 * 256
	assign dt = signed'({1'b0, in_data.temperature_raw})
		- signed'({1'b0, cfg.reference_temperature, 8'h0});

	// Stage 2: one multiplier per coefficient
	assign p6 = PROD_W'(dt_s1) * PROD_W'(signed'({1'b0, cfg.temp_coef}));
	assign p4 = PROD_W'(dt_s1) * PROD_W'(signed'({1'b0, cfg.offset_temp_coef}));
	assign p3 = PROD_W'(dt_s1) * PROD_W'(signed'({1'b0, cfg.sens_temp_coef}));

	// Stage 3: arithmetic shifts are the upper slices of the products
	assign comp.temp = signed'(p6_s2[PROD_W-1:23]) + TEMP_BASE;
	assign comp.off  = signed'({3'b000, cfg.pressure_offset, 16'h0})
		+ signed'(p4_s2[PROD_W-1:7]);
	assign comp.sens = signed'({3'b000, cfg.pressure_sensitivity, 15'h0})
		+ signed'(p3_s2[PROD_W-1:8]);
	assign comp.d1   = d1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dt_s1 <= dt;
			d1_s1 <= in_data.pressure_raw;
		end
		if (rdy2) begin
			p6_s2 <= p6;
			p4_s2 <= p4;
			p3_s2 <= p3;
			d1_s2 <= d1_s1;
		end
		if (rdy3) begin
			comp_s3 <= comp;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = comp_s3;

endmodule

// File: rtl/bsc_press.sv
// Stages 4 to 6: D1 * SENS in two partial products, recombine, subtract OFF,
// scale and clamp the pressure. Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_press (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bsc_pkg::comp_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bsc_pkg::result_t out_data
);
	import bsc_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic rdy4, rdy5, rdy6;

	logic [PL_W-1:0]          pl_s4;
	logic signed [PH_W-1:0]   ph_s4;
	logic signed [OFF_W-1:0]  off_s4, off_s5;
	logic signed [TEMP_W-1:0] temp_s4, temp_s5;
	logic signed [Q_W-1:0]    q_s5;
	result_t                  res_s6;

	logic [PL_W-1:0]          pl;
	logic signed [PH_W-1:0]   ph;
	logic signed [FULL_W-1:0] full;
	logic signed [DIFF_W-1:0] diff;
	logic signed [P_W-1:0]    p;
	result_t                  res;

	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign in_ready = rdy4;

	// Stage 4: SENS split into unsigned low and signed high 17-bit halves
	assign pl = PL_W'(in_data.d1) * PL_W'(in_data.sens[16:0]);
	assign ph = PH_W'(signed'({1'b0, in_data.d1}))
		* PH_W'(signed'(in_data.sens[SENS_W-1:17]));

	// Stage 5: D1*SENS = ph*2^17 + pl, then >> 21
	assign full = signed'({ph_s4, 17'h0}) + signed'({18'h0, pl_s4});

	// Stage 6: (q - OFF) >> 15 and clamp to 0..131071
	assign diff = signed'({q_s5[Q_W-1], q_s5}) - signed'({{4{off_s5[OFF_W-1]}}, off_s5});
	assign p    = diff[DIFF_W-1:15];

	always_comb begin
		res.temperature_centi = temp_s5;
		priority if (p[P_W-1]) begin
			res.pressure_centi     = 17'd0;
			res.pressure_saturated = 1'b1;
		end else if (p[P_W-2:17] != '0) begin
			res.pressure_centi     = P_MAX;
			res.pressure_saturated = 1'b1;
		end else begin
			res.pressure_centi     = p[16:0];
			res.pressure_saturated = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy4) v_s4 <= in_valid;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			pl_s4   <= pl;
			ph_s4   <= ph;
			off_s4  <= in_data.off;
			temp_s4 <= in_data.temp;
		end
		if (rdy5) begin
			q_s5    <= full[FULL_W-1:21];
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
		end
		if (rdy6) begin
			res_s6 <= res;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule

// File: rtl/bsc_checker.sv
// Port-level assertions for baro_sensor_compensation, bound to the top level.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [bsc_pkg::ADDR_W-1:0] paddr,
	input logic [bsc_pkg::DATA_W-1:0] pwdata,
	input logic [bsc_pkg::DATA_W-1:0] prdata,
	input logic                       pready,
	input logic                       sample_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input bsc_pkg::result_t           result
);
	import bsc_pkg::*;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready
		&& paddr[4:2] <= REG_TEMP_COEF;

	// A held result keeps its value until the transaction completes
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Input back-pressure only comes from a stalled, full output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("sample_ready low without output stall");

	// A clamped pressure sits exactly at one end of its range
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pressure_saturated |->
			result.pressure_centi == 17'd0 || result.pressure_centi == P_MAX)
		else $error("saturated pressure not at a limit");

	// A written coefficient reads back on the next cycle
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr ##1 (paddr == $past(paddr)) |->
			prdata == {16'h0, $past(pwdata[15:0])})
		else $error("register readback mismatch");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

// File: sim/baro_sensor_compensation_tb.sv
// Self-checking testbench for baro_sensor_compensation: drives samples and
// calibration writes, and checks each result against its own predictor.
// Depends on bsc_pkg and the block's RTL.
`timescale 1ns / 1ps

module baro_sensor_compensation_tb;
	import bsc_pkg::*;

	localparam int LATENCY          = 6;
	localparam int CYCLE_LIMIT      = 500000;
	localparam int RAND_PHASES      = 12;
	localparam int ITEMS_PER_PHASE  = 153;
	localparam int MAX_REPORTS      = 10;

	// Index codes the block must ignore
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam cfg_t DATASHEET_CAL = '{16'd40127, 16'd36924, 16'd23317,
		16'd23282, 16'd33464, 16'd28312};

	class compensation_scoreboard;
		cfg_t    cal;
		result_t pending_readings[$];
		int      checked;
		int      clamped;
		int      mismatches;

		function new();
			cal = '0;
			checked = 0;
			clamped = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_PRESS_SENS: cal.pressure_sensitivity = data[15:0];
				REG_PRESS_OFF: cal.pressure_offset = data[15:0];
				REG_SENS_TCO: cal.sens_temp_coef = data[15:0];
				REG_OFF_TCO: cal.offset_temp_coef = data[15:0];
				REG_TREF: cal.reference_temperature = data[15:0];
				REG_TEMP_COEF: cal.temp_coef = data[15:0];
				default: ;
			endcase
		endfunction

		// First-order compensation in 64-bit signed arithmetic; >>> floors.
		function result_t compensate(sample_t s);
			longint d1, d2, c1, c2, c3, c4, c5, c6;
			longint dt, temp_c, off, sens, p;
			result_t r;
			d1 = s.pressure_raw;
			d2 = s.temperature_raw;
			c1 = cal.pressure_sensitivity;
			c2 = cal.pressure_offset;
			c3 = cal.sens_temp_coef;
			c4 = cal.offset_temp_coef;
			c5 = cal.reference_temperature;
			c6 = cal.temp_coef;
			dt = d2 - c5 * 256;
			temp_c = longint'(TEMP_BASE) + ((dt * c6) >>> 23);
			off = c2 * 65536 + ((c4 * dt) >>> 7);
			sens = c1 * 32768 + ((c3 * dt) >>> 8);
			p = (((d1 * sens) >>> 21) - off) >>> 15;
			r.pressure_saturated = 1'b0;
			if (p < 0) begin
				p = 0;
				r.pressure_saturated = 1'b1;
			end else if (p > longint'(P_MAX)) begin
				p = longint'(P_MAX);
				r.pressure_saturated = 1'b1;
			end
			r.temperature_centi = temp_c[18:0];
			r.pressure_centi = p[16:0];
			return r;
		endfunction

		function void note_sample(sample_t s);
			pending_readings.push_back(compensate(s));
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: temp=%0d press=%0d sat=%0b",
						$signed(got.temperature_centi), got.pressure_centi,
						got.pressure_saturated);
				return;
			end
			want = pending_readings.pop_front();
			checked++;
			if (want.pressure_saturated)
				clamped++;
			if (got.temperature_centi !== want.temperature_centi ||
					got.pressure_centi !== want.pressure_centi ||
					got.pressure_saturated !== want.pressure_saturated) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("result %0d mismatch: expected temp=%0d press=%0d sat=%0b,",
						checked, $signed(want.temperature_centi), want.pressure_centi,
						want.pressure_saturated);
					$display("  got temp=%0d press=%0d sat=%0b",
						$signed(got.temperature_centi), got.pressure_centi,
						got.pressure_saturated);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	sample_t             sample = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;

	compensation_scoreboard readings = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int samples_sent = 0;
	int settings_used = 0;
	int cycles = 0;

	baro_sensor_compensation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("baro_sensor_compensation regression: fail");
			$finish;
		end
	end

	// Sample both handshakes with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				readings.note_sample(sample);
			if (result_valid && result_ready)
				readings.check_result(result);
		end
	end

	// Receiver: when rx_idle is set, stall a random number of cycles before each transaction
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Leaves the bus in its access phase; the caller returns it to idle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readings.set_reg(idx, data);
	endtask

	// Load all six coefficients, sometimes also a spare index; junk in the upper bits must be dropped
	task automatic apply_cal(input cfg_t c);
		write_reg(REG_PRESS_SENS, {16'($urandom()), c.pressure_sensitivity});
		write_reg(REG_PRESS_OFF, {16'($urandom()), c.pressure_offset});
		write_reg(REG_SENS_TCO, {16'($urandom()), c.sens_temp_coef});
		write_reg(REG_OFF_TCO, {16'($urandom()), c.offset_temp_coef});
		write_reg(REG_TREF, {16'($urandom()), c.reference_temperature});
		write_reg(REG_TEMP_COEF, {16'($urandom()), c.temp_coef});
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic push_sample(input logic [23:0] d1, input logic [23:0] d2);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{pressure_raw: d1, temperature_raw: d2};
		do @(posedge clk); while (!sample_ready);
		samples_sent++;
	endtask

	// Drop valid, wait until every expected result is back, then hold a while
	task automatic settle(input int tail);
		sample_valid <= 1'b0;
		@(posedge clk);
		while (readings.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	function automatic logic [23:0] corner_value();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'h800000;
			3: return 24'h7FFFFF;
			4: return 24'h000001;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] jitter(input logic [15:0] base);
		int v;
		v = int'(base) + $urandom_range(0, 8191) - 4096;
		return v[15:0];
	endfunction

	task automatic push_random(input logic [15:0] tref);
		int pick;
		int t;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			// Plausible conversions around the reference temperature
			t = int'(tref) * 256 + $urandom_range(0, 6000000) - 3000000;
			if (t < 0)
				t = 0;
			if (t > 24'hFFFFFF)
				t = 24'hFFFFFF;
			push_sample(24'($urandom_range(4000000, 11000000)), t[23:0]);
		end else if (pick < 8) begin
			push_sample(24'($urandom()), 24'($urandom()));
		end else begin
			push_sample(corner_value(), corner_value());
		end
	endtask

	initial begin
		int ph, i;
		cfg_t c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coefficients straight out of reset are all zero
		push_sample(24'h000000, 24'h000000);
		push_sample(24'hFFFFFF, 24'hFFFFFF);
		settle(LATENCY + 2);

		apply_cal(DATASHEET_CAL);
		push_sample(24'd9085466, 24'd8569150);
		push_sample(24'h000000, 24'd8569150);   // negative pressure clamps to zero
		push_sample(24'hFFFFFF, 24'd8569150);   // clamps at full scale
		push_sample(24'd9085466, 24'h000000);
		push_sample(24'd9085466, 24'hFFFFFF);
		push_sample(24'hFFFFFF, 24'h000000);
		push_sample(24'h000000, 24'hFFFFFF);
		settle(LATENCY + 2);

		apply_cal('1);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		push_sample(24'h000000, 24'h000000);    // coldest temperature
		push_sample(24'hFFFFFF, 24'hFFFFFF);
		push_sample(24'hFFFFFF, 24'h000000);
		push_sample(24'h000000, 24'hFFFFFF);
		push_sample(24'hAAAAAA, 24'h555555);
		settle(LATENCY + 2);

		c = '{pressure_sensitivity: 16'hFFFF, pressure_offset: 16'h0000,
			sens_temp_coef: 16'hFFFF, offset_temp_coef: 16'h0000,
			reference_temperature: 16'h0000, temp_coef: 16'hFFFF};
		apply_cal(c);
		push_sample(24'hFFFFFF, 24'hFFFFFF);    // hottest temperature
		push_sample(24'h800000, 24'h800000);
		push_sample(24'h000001, 24'h000001);
		settle(LATENCY + 2);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			tx_idle = (ph % 4 == 0) || (ph % 4 == 2);
			rx_idle = (ph % 4 == 0) || (ph % 4 == 3);
			if (ph == 3)
				c = '1;
			else if (ph == 7)
				c = '0;
			else if (ph % 2 == 0)
				c = '{jitter(DATASHEET_CAL.pressure_sensitivity),
					jitter(DATASHEET_CAL.pressure_offset),
					jitter(DATASHEET_CAL.sens_temp_coef),
					jitter(DATASHEET_CAL.offset_temp_coef),
					jitter(DATASHEET_CAL.reference_temperature),
					jitter(DATASHEET_CAL.temp_coef)};
			else
				c = {$urandom(), $urandom(), $urandom()};
			apply_cal(c);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2 && ph % 3 == 0)
					settle(0);
				push_random(c.reference_temperature);
			end
			settle(LATENCY + 2);
		end

		settle(LATENCY + 4);
		$display("Sent %0d samples across %0d calibration settings; %0d results checked,",
			samples_sent, settings_used, readings.checked);
		$display("%0d of them with clamped pressure; %0d mismatches.",
			readings.clamped, readings.mismatches);
		if (readings.mismatches == 0 && readings.pending() == 0)
			$display("baro_sensor_compensation regression: pass");
		else
			$display("baro_sensor_compensation regression: fail");
		$finish;
	end

endmodule
